>>> rtl/core/meinv_pkg.sv
package meinv_pkg;

	// Default operand width; the block works for widths from 8 to 63.
	localparam int unsigned OPERAND_WIDTH_DEF = 31;

endpackage

>>> rtl/core/meinv_div.sv
module meinv_div
	import meinv_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [OPERAND_WIDTH-1:0]          dividend,
	input  logic [OPERAND_WIDTH-1:0]          divisor,
	input  logic signed [OPERAND_WIDTH:0]     coef,
	output logic                              done,
	output logic [OPERAND_WIDTH-1:0]          remainder,
	output logic signed [OPERAND_WIDTH+1:0]   product
);

	localparam int unsigned W  = OPERAND_WIDTH;
	localparam int unsigned CW = $clog2(W);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [W-1:0]          num_q;
	logic [W-1:0]          den_q;
	logic [W-1:0]          rem_q;
	logic signed [W:0]     coef_q;
	logic signed [W+1:0]   prod_q;

	logic [W:0]            trial;
	logic [W+1:0]          diff;
	logic                  qbit;
	logic signed [W+1:0]   coef_ext;
	logic signed [W+1:0]   prod_nxt;

	// One quotient bit per cycle, most significant first. The product of the
	// quotient and the coefficient is built alongside by shift and add, so the
	// full quotient is never needed.
	always_comb begin
		trial    = {rem_q, num_q[W-1]};
		diff     = {1'b0, trial} - {2'b00, den_q};
		qbit     = ~diff[W+1];
		coef_ext = {coef_q[W], coef_q};
		prod_nxt = (prod_q <<< 1) + (qbit ? coef_ext : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= dividend;
			den_q  <= divisor;
			coef_q <= coef;
			rem_q  <= '0;
			prod_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[W-2:0], 1'b0};
			rem_q  <= qbit ? diff[W-1:0] : trial[W-1:0];
			prod_q <= prod_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
	assign product   = prod_q;

endmodule

>>> rtl/core/modular_inverse_ext_euclid_top.sv
// Modular inverse by the extended Euclidean algorithm.
// Request channel: req_valid / req_stall with first_operand and second_operand.
// The larger operand is the modulus; the smaller one is inverted modulo it.
// Response channel: rsp_valid / rsp_stall with inverse, common_divisor and
// is_coprime. One response follows every request transfer.
// Each Euclid step passes through ST_CHECK and ST_DIVIDE, set by the shared
// bit-serial divider that yields one quotient bit per cycle. rsp_valid is set
// when ST_FINISH finds the output register free; for 31-bit operands there are
// at most about 45 steps. A zero operand skips the loop: the request passes
// through ST_CHECK and ST_FINISH only, and the next request can be taken in
// the same cycle in which rsp_valid rises.
// req_stall is high while an item is in work; one item is handled at a time.
// A finished response sits in the output register until its transfer, and the
// next request may be taken meanwhile; its result waits for the register.
// Reset clears the sequencer and the divider control and drops rsp_valid; the data registers are not reset.
module modular_inverse_ext_euclid_top
	import meinv_pkg::*;
#(
	parameter int unsigned OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [OPERAND_WIDTH-1:0] first_operand,
	input  logic [OPERAND_WIDTH-1:0] second_operand,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic [OPERAND_WIDTH-1:0] inverse,
	output logic [OPERAND_WIDTH-1:0] common_divisor,
	output logic                     is_coprime
);

	localparam int unsigned W = OPERAND_WIDTH;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic                 rsp_valid_q;
	logic [W-1:0]         inverse_q;
	logic [W-1:0]         gcd_q;
	logic                 coprime_q;

	logic [W-1:0]         mod_q;
	logic [W-1:0]         rhi_q;
	logic [W-1:0]         rlo_q;
	logic signed [W:0]    chi_q;
	logic signed [W:0]    clo_q;

	logic                 div_start;
	logic                 div_done;
	logic [W-1:0]         div_rem;
	logic signed [W+1:0]  div_prod;

	logic                 req_xfer;
	logic                 rsp_free;
	logic signed [W+1:0]  coef_nxt;
	logic signed [W+1:0]  coef_fix;

	assign req_xfer  = req_valid && (state_q == ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign div_start = (state_q == ST_CHECK) && (rlo_q != '0);

	// The true coefficients never exceed the modulus in magnitude, so the
	// difference fits back into the coefficient registers.
	assign coef_nxt = {chi_q[W], chi_q} - div_prod;
	assign coef_fix = {chi_q[W], chi_q} + {2'b00, mod_q};

	meinv_div #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rhi_q),
		.divisor  (rlo_q),
		.coef     (clo_q),
		.done     (div_done),
		.remainder(div_rem),
		.product  (div_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FINISH) && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= (rlo_q == '0) ? ST_FINISH : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (div_done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_FINISH: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			if (first_operand < second_operand) begin
				mod_q <= second_operand;
				rhi_q <= second_operand;
				rlo_q <= first_operand;
			end else begin
				mod_q <= first_operand;
				rhi_q <= first_operand;
				rlo_q <= second_operand;
			end
			chi_q <= '0;
			clo_q <= (W+1)'(1);
		end else if ((state_q == ST_DIVIDE) && div_done) begin
			rhi_q <= rlo_q;
			rlo_q <= div_rem;
			chi_q <= clo_q;
			clo_q <= coef_nxt[W:0];
		end
		if ((state_q == ST_FINISH) && rsp_free) begin
			inverse_q <= chi_q[W] ? coef_fix[W-1:0] : chi_q[W-1:0];
			gcd_q     <= rhi_q;
			coprime_q <= (rhi_q == W'(1));
		end
	end

	assign req_stall      = (state_q != ST_IDLE);
	assign rsp_valid      = rsp_valid_q;
	assign inverse        = inverse_q;
	assign common_divisor = gcd_q;
	assign is_coprime     = coprime_q;

endmodule
